// ===== hw/rtl/box_blur_3x3_edge_average_top_macros.svh =====
// ----------------------------------------------------------------------------
// Box blur assertion macros
// Shorthand for the clocked, reset-qualified checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_EDGE_AVERAGE_TOP_MACROS_SVH
`define BOX_BLUR_3X3_EDGE_AVERAGE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BB3_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("box blur assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BB3_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("box blur assertion failed");

`endif

// ===== hw/rtl/bb3_pkg.sv =====
// ----------------------------------------------------------------------------
// Box blur package
// Shared widths, configuration codes, divisor codes and line store request.
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int MaxWidth = 32;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int PixW     = 8;
  localparam int ColSumW  = 10;
  localparam int SumW     = 12;
  localparam int WidthW   = 6;
  localparam int HeightW  = 12;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 12;

  localparam logic [CfgIdxW-1:0] CfgImageWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgImageHeight = 2'd1;

  localparam logic [WidthW-1:0]  WidthReset  = 6'd32;
  localparam logic [HeightW-1:0] HeightReset = 12'd32;

  // Reciprocals for division by 6 and 9, exact for sums below 3277.
  localparam int          RecipShift = 14;
  localparam logic [11:0] Recip6     = 12'd2731;
  localparam logic [11:0] Recip9     = 12'd1821;

  // Number of neighbors that went into a sum.
  typedef enum logic [1:0] {
    DIV4,
    DIV6,
    DIV9
  } div_e;

  typedef struct packed {
    logic            rd_en;
    logic [ColW-1:0] rd_addr;
    logic            wr_en;
    logic [ColW-1:0] wr_addr;
    logic [PixW-1:0] wr_older;
    logic [PixW-1:0] wr_newer;
  } ls_req_t;

endpackage

// ===== hw/rtl/bb3_line_store.sv =====
// ----------------------------------------------------------------------------
// Box blur line store
// Two row memories sharing one address pair, with registered read data.
// ----------------------------------------------------------------------------
module bb3_line_store (
  input  logic                    clk_i,
  input  bb3_pkg::ls_req_t        req_i,
  output logic [bb3_pkg::PixW-1:0] older_o,
  output logic [bb3_pkg::PixW-1:0] newer_o
);

  logic [bb3_pkg::PixW-1:0] older_mem_q [bb3_pkg::MaxWidth];
  logic [bb3_pkg::PixW-1:0] newer_mem_q [bb3_pkg::MaxWidth];
  logic [bb3_pkg::PixW-1:0] older_rd_q;
  logic [bb3_pkg::PixW-1:0] newer_rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      older_mem_q[req_i.wr_addr] <= req_i.wr_older;
      newer_mem_q[req_i.wr_addr] <= req_i.wr_newer;
    end
    if (req_i.rd_en) begin
      older_rd_q <= older_mem_q[req_i.rd_addr];
      newer_rd_q <= newer_mem_q[req_i.rd_addr];
    end
  end

  assign older_o = older_rd_q;
  assign newer_o = newer_rd_q;

endmodule

// ===== hw/rtl/bb3_mean.sv =====
// ----------------------------------------------------------------------------
// Box blur mean unit
// Divides a neighborhood sum by 4, 6 or 9 with a shift or a reciprocal.
// ----------------------------------------------------------------------------
module bb3_mean (
  input  logic [bb3_pkg::SumW-1:0] sum_i,
  input  bb3_pkg::div_e            div_i,
  output logic [bb3_pkg::PixW-1:0] mean_o
);

  logic [11:0]                 recip;
  logic [bb3_pkg::SumW+11:0]   prod;

  always_comb begin
    recip = (div_i == bb3_pkg::DIV9) ? bb3_pkg::Recip9 : bb3_pkg::Recip6;
    prod  = {12'd0, sum_i} * {{bb3_pkg::SumW{1'b0}}, recip};
    case (div_i)
      bb3_pkg::DIV4: mean_o = sum_i[bb3_pkg::PixW+1:2];
      bb3_pkg::DIV6,
      bb3_pkg::DIV9: mean_o = prod[bb3_pkg::RecipShift +: bb3_pkg::PixW];
      default:       mean_o = sum_i[bb3_pkg::PixW+1:2];
    endcase
  end

endmodule

// ===== hw/rtl/box_blur_3x3_edge_average_top.sv =====
// ----------------------------------------------------------------------------
// Box blur 3x3 with edge averaging
// Streaming mean filter over the in-image 3x3 neighborhood of each pixel.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one transfer each, and results leave in raster
// order one row and one column behind. Each pixel passes a calculate state;
// a pixel of a later row past its first column then gives a result from an
// emit state, and the pixel at the end of such a row gives two results from
// two emit states. The last pixel of the image then flushes the final row
// from the line stores. The sequencer uses the single read port of the line
// stores and the single output register in turn, taking a new pixel only when
// idle; stalls on the output hold it. Writing either register restarts the
// image; the line stores keep their contents.
`include "box_blur_3x3_edge_average_top_macros.svh"

module box_blur_3x3_edge_average_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write port
  input  logic                        cfg_we_i,
  input  logic [bb3_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bb3_pkg::CfgDataW-1:0] cfg_data_i,
  // Pixel input
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [7:0]                  s_axis_tdata_i,   // [7:0] pixel
  // Result output
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [7:0]                  m_axis_tdata_o,   // [7:0] smoothed
  output logic                        m_axis_tlast_o,   // last_of_run
  output logic                        m_axis_tuser_o    // [0] end_of_image
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_EMIT_A,
    S_EMIT_B,
    S_FL_READ,
    S_FL_DATA,
    S_FL_EMIT,
    S_FL_TAIL
  } state_e;

  state_e                          state_q;
  logic [bb3_pkg::WidthW-1:0]      width_q;
  logic [bb3_pkg::HeightW-1:0]     height_q;
  logic [bb3_pkg::HeightW-1:0]     row_q;
  logic [bb3_pkg::ColW-1:0]        col_q;
  logic [bb3_pkg::ColW-1:0]        fl_k_q;
  logic [bb3_pkg::PixW-1:0]        pix_q;
  logic [bb3_pkg::ColSumW-1:0]     one_back_q;
  logic [bb3_pkg::ColSumW-1:0]     two_back_q;
  logic [bb3_pkg::PixW:0]          win0_q;
  logic [bb3_pkg::PixW:0]          win1_q;
  logic [bb3_pkg::SumW-1:0]        sum_a_q;
  bb3_pkg::div_e                   div_a_q;
  logic [bb3_pkg::SumW-1:0]        sum_b_q;
  bb3_pkg::div_e                   div_b_q;
  logic                            has_b_q;
  logic                            flush_q;
  logic                            out_valid_q;
  logic [bb3_pkg::PixW-1:0]        out_data_q;
  logic                            out_last_q;
  logic                            out_eoi_q;

  logic [bb3_pkg::ColW-1:0]        w_last;
  logic [bb3_pkg::HeightW-1:0]     h_eff;
  logic [bb3_pkg::ColW-1:0]        c_eff;
  logic                            in_accept;
  logic                            out_free;
  logic                            rows3;
  logic                            row_end;
  logic                            last_row;
  logic [bb3_pkg::ColSumW-1:0]     col_sum;
  logic [bb3_pkg::SumW-1:0]        calc_sum_a;
  logic [bb3_pkg::SumW-1:0]        calc_sum_b;
  logic [bb3_pkg::PixW:0]          fl_col;
  logic [bb3_pkg::SumW-1:0]        fl_sum;
  logic [bb3_pkg::SumW-1:0]        mean_sum;
  bb3_pkg::div_e                   mean_div;
  logic [bb3_pkg::PixW-1:0]        mean;
  logic [bb3_pkg::PixW-1:0]        older_rd;
  logic [bb3_pkg::PixW-1:0]        newer_rd;
  bb3_pkg::ls_req_t                ls_req;

  // Effective image size: width clamped to 2..MaxWidth, height at least 2.
  always_comb begin
    if (width_q < 6'd2) begin
      w_last = bb3_pkg::ColW'(1);
    end else if (width_q > bb3_pkg::WidthW'(bb3_pkg::MaxWidth)) begin
      w_last = bb3_pkg::ColW'(bb3_pkg::MaxWidth - 1);
    end else begin
      w_last = bb3_pkg::ColW'(width_q - 6'd1);
    end
    h_eff = (height_q < 12'd2) ? 12'd2 : height_q;
    c_eff = (col_q > w_last) ? w_last : col_q;
  end

  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // Column sums for the pixel being processed and for the flush pass.
  always_comb begin
    rows3      = (row_q >= 12'd2);
    row_end    = (col_q == w_last);
    last_row   = (row_q >= h_eff - 12'd1);
    col_sum    = {2'd0, newer_rd} + {2'd0, pix_q} + (rows3 ? {2'd0, older_rd} : 10'd0);
    calc_sum_a = ((col_q >= bb3_pkg::ColW'(2)) ? {2'd0, two_back_q} : 12'd0)
               + {2'd0, one_back_q} + {2'd0, col_sum};
    calc_sum_b = {2'd0, one_back_q} + {2'd0, col_sum};
    fl_col     = {1'b0, older_rd} + {1'b0, newer_rd};
    fl_sum     = ((fl_k_q >= bb3_pkg::ColW'(2)) ? {3'd0, win1_q} : 12'd0)
               + {3'd0, win0_q} + {3'd0, fl_col};
  end

  always_comb begin
    ls_req          = '0;
    ls_req.rd_en    = in_accept || (state_q == S_FL_READ);
    ls_req.rd_addr  = (state_q == S_FL_READ) ? fl_k_q : c_eff;
    ls_req.wr_en    = (state_q == S_CALC);
    ls_req.wr_addr  = col_q;
    ls_req.wr_older = newer_rd;
    ls_req.wr_newer = pix_q;
  end

  bb3_line_store u_line_store (
    .clk_i   (clk_i),
    .req_i   (ls_req),
    .older_o (older_rd),
    .newer_o (newer_rd)
  );

  assign mean_sum = (state_q == S_EMIT_B) ? sum_b_q : sum_a_q;
  assign mean_div = (state_q == S_EMIT_B) ? div_b_q : div_a_q;

  bb3_mean u_mean (
    .sum_i  (mean_sum),
    .div_i  (mean_div),
    .mean_o (mean)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      width_q     <= bb3_pkg::WidthReset;
      height_q    <= bb3_pkg::HeightReset;
      row_q       <= '0;
      col_q       <= '0;
      fl_k_q      <= '0;
      pix_q       <= '0;
      one_back_q  <= '0;
      two_back_q  <= '0;
      win0_q      <= '0;
      win1_q      <= '0;
      sum_a_q     <= '0;
      div_a_q     <= bb3_pkg::DIV4;
      sum_b_q     <= '0;
      div_b_q     <= bb3_pkg::DIV4;
      has_b_q     <= 1'b0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
      out_eoi_q   <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            pix_q   <= s_axis_tdata_i;
            col_q   <= c_eff;
            state_q <= S_CALC;
          end
        end

        S_CALC: begin
          sum_a_q    <= calc_sum_a;
          if (col_q >= bb3_pkg::ColW'(2)) begin
            div_a_q <= rows3 ? bb3_pkg::DIV9 : bb3_pkg::DIV6;
          end else begin
            div_a_q <= rows3 ? bb3_pkg::DIV6 : bb3_pkg::DIV4;
          end
          sum_b_q    <= calc_sum_b;
          div_b_q    <= rows3 ? bb3_pkg::DIV6 : bb3_pkg::DIV4;
          has_b_q    <= row_end;
          flush_q    <= row_end && last_row;
          two_back_q <= one_back_q;
          one_back_q <= col_sum;
          if (row_end) begin
            col_q <= '0;
            row_q <= last_row ? 12'd0 : row_q + 12'd1;
          end else begin
            col_q <= col_q + bb3_pkg::ColW'(1);
          end
          // A pixel of a later row at column one or beyond gives a result.
          if ((row_q != 12'd0) && (col_q != '0)) begin
            state_q <= S_EMIT_A;
          end else begin
            state_q <= S_IDLE;
          end
        end

        S_EMIT_A: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= mean;
            out_last_q  <= !has_b_q;
            out_eoi_q   <= 1'b0;
            state_q     <= has_b_q ? S_EMIT_B : S_IDLE;
          end
        end

        S_EMIT_B: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= mean;
            out_last_q  <= !flush_q;
            out_eoi_q   <= 1'b0;
            fl_k_q      <= '0;
            state_q     <= flush_q ? S_FL_READ : S_IDLE;
          end
        end

        S_FL_READ: begin
          state_q <= S_FL_DATA;
        end

        S_FL_DATA: begin
          win0_q <= fl_col;
          win1_q <= win0_q;
          if (fl_k_q == '0) begin
            fl_k_q  <= fl_k_q + bb3_pkg::ColW'(1);
            state_q <= S_FL_READ;
          end else begin
            sum_a_q <= fl_sum;
            div_a_q <= (fl_k_q >= bb3_pkg::ColW'(2)) ? bb3_pkg::DIV6 : bb3_pkg::DIV4;
            state_q <= S_FL_EMIT;
          end
        end

        S_FL_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= mean;
            out_last_q  <= 1'b0;
            out_eoi_q   <= 1'b0;
            if (fl_k_q == w_last) begin
              // The rightmost column sees only itself and its left neighbor.
              sum_a_q <= {3'd0, win0_q} + {3'd0, win1_q};
              div_a_q <= bb3_pkg::DIV4;
              state_q <= S_FL_TAIL;
            end else begin
              fl_k_q  <= fl_k_q + bb3_pkg::ColW'(1);
              state_q <= S_FL_READ;
            end
          end
        end

        S_FL_TAIL: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= mean;
            out_last_q  <= 1'b1;
            out_eoi_q   <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase

      // A register write restarts the image.
      if (cfg_we_i) begin
        case (cfg_index_i)
          bb3_pkg::CfgImageWidth: begin
            width_q <= cfg_data_i[bb3_pkg::WidthW-1:0];
            row_q   <= '0;
            col_q   <= '0;
          end
          bb3_pkg::CfgImageHeight: begin
            height_q <= cfg_data_i[bb3_pkg::HeightW-1:0];
            row_q    <= '0;
            col_q    <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_eoi_q;

  `BB3_ASSERT_SAME(a_eoi_is_last, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tlast_o)
  `BB3_ASSERT_NEXT(a_one_pixel_in_flight, in_accept, !s_axis_tready_o)
  `BB3_ASSERT_SAME(a_write_in_row, ls_req.wr_en, ls_req.wr_addr <= w_last)
  `BB3_ASSERT_SAME(a_flush_in_row, state_q == S_FL_READ, fl_k_q <= w_last)

endmodule

// ===== verif/tb_box_blur_3x3_edge_average_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box blur 3x3 testbench
// Streams images of many sizes through the filter under random input gaps and
// output stalls. A behavioral line buffer model predicts every smoothed pixel,
// and each output transfer is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_edge_average_top;

  localparam int RandomItems  = 287;
  localparam int SettleCycles = 3 * bb3_pkg::MaxWidth + 16;
  localparam int NumDirected  = 31;

  // Indexes past the register list; writes to them must change nothing.
  localparam logic [bb3_pkg::CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [bb3_pkg::CfgIdxW-1:0] CfgSpareB = 2'd3;

  typedef struct packed {
    logic [bb3_pkg::PixW-1:0] smoothed;
    logic                     last_of_run;
    logic                     end_of_image;
  } blur_result_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_PIX,
    ROW_PIX_MEAN
  } row_kind_e;

  // For pixel rows, value[7:0] is the pixel and index is unused.
  typedef struct packed {
    row_kind_e                      kind;
    logic [bb3_pkg::CfgIdxW-1:0]    index;
    logic [bb3_pkg::CfgDataW-1:0]   value;
    logic [bb3_pkg::PixW-1:0]       mean;
  } directed_row_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_HALF,
    READY_SPARSE
  } ready_mode_e;

  localparam directed_row_t DirectedRows [NumDirected] = '{
    // Default 32x32 image straight after reset: first row gives nothing.
    '{ROW_PIX,      bb3_pkg::CfgImageWidth,  12'd17,    8'd0},
    '{ROW_PIX,      bb3_pkg::CfgImageWidth,  12'd200,   8'd0},
    // Smallest image, uniform white then uniform black.
    '{ROW_CFG,      bb3_pkg::CfgImageWidth,  12'd2,     8'd0},
    '{ROW_CFG,      bb3_pkg::CfgImageHeight, 12'd2,     8'd0},
    '{ROW_PIX_MEAN, bb3_pkg::CfgImageWidth,  12'd255,   8'd255},
    '{ROW_PIX_MEAN, bb3_pkg::CfgImageWidth,  12'd255,   8'd255},
    '{ROW_PIX_MEAN, bb3_pkg::CfgImageWidth,  12'd255,   8'd255},
    '{ROW_PIX_MEAN, bb3_pkg::CfgImageWidth,  12'd255,   8'd255},
    '{ROW_PIX_MEAN, bb3_pkg::CfgImageWidth,  12'd0,     8'd0},
    '{ROW_PIX_MEAN, bb3_pkg::CfgImageWidth,  12'd0,     8'd0},
    '{ROW_PIX_MEAN, bb3_pkg::CfgImageWidth,  12'd0,     8'd0},
    '{ROW_PIX_MEAN, bb3_pkg::CfgImageWidth,  12'd0,     8'd0},
    // Width of zero (upper data bits set) and height of one clamp to two.
    '{ROW_CFG,      bb3_pkg::CfgImageWidth,  12'hFC0,   8'd0},
    '{ROW_CFG,      bb3_pkg::CfgImageHeight, 12'd1,     8'd0},
    '{ROW_CFG,      CfgSpareA,               12'hFFF,   8'd0},
    '{ROW_PIX,      bb3_pkg::CfgImageWidth,  12'd255,   8'd0},
    '{ROW_PIX,      bb3_pkg::CfgImageWidth,  12'd0,     8'd0},
    '{ROW_PIX,      bb3_pkg::CfgImageWidth,  12'd0,     8'd0},
    '{ROW_PIX,      bb3_pkg::CfgImageWidth,  12'd255,   8'd0},
    // 3x3 checkerboard with a spare-index write in the middle of the image.
    '{ROW_CFG,      bb3_pkg::CfgImageWidth,  12'd3,     8'd0},
    '{ROW_CFG,      bb3_pkg::CfgImageHeight, 12'd3,     8'd0},
    '{ROW_PIX,      bb3_pkg::CfgImageWidth,  12'd0,     8'd0},
    '{ROW_PIX,      bb3_pkg::CfgImageWidth,  12'd255,   8'd0},
    '{ROW_PIX,      bb3_pkg::CfgImageWidth,  12'd0,     8'd0},
    '{ROW_PIX,      bb3_pkg::CfgImageWidth,  12'd255,   8'd0},
    '{ROW_CFG,      CfgSpareB,               12'h5A5,   8'd0},
    '{ROW_PIX,      bb3_pkg::CfgImageWidth,  12'd0,     8'd0},
    '{ROW_PIX,      bb3_pkg::CfgImageWidth,  12'd255,   8'd0},
    '{ROW_PIX,      bb3_pkg::CfgImageWidth,  12'd0,     8'd0},
    '{ROW_PIX,      bb3_pkg::CfgImageWidth,  12'd255,   8'd0},
    '{ROW_PIX,      bb3_pkg::CfgImageWidth,  12'd0,     8'd0}
  };

  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         cfg_we_i        = 1'b0;
  logic [bb3_pkg::CfgIdxW-1:0]  cfg_index_i     = '0;
  logic [bb3_pkg::CfgDataW-1:0] cfg_data_i      = '0;
  logic                         s_axis_tvalid_i = 1'b0;
  logic                         s_axis_tready_o;
  logic [7:0]                   s_axis_tdata_i  = '0;   // [7:0] pixel
  logic                         m_axis_tvalid_o;
  logic                         m_axis_tready_i = 1'b0;
  logic [7:0]                   m_axis_tdata_o;         // [7:0] smoothed
  logic                         m_axis_tlast_o;         // last_of_run
  logic                         m_axis_tuser_o;         // [0] end_of_image

  box_blur_3x3_edge_average_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Model of the filter state.
  logic [bb3_pkg::PixW-1:0]    line_older [bb3_pkg::MaxWidth];
  logic [bb3_pkg::PixW-1:0]    line_newer [bb3_pkg::MaxWidth];
  logic [bb3_pkg::WidthW-1:0]  cfg_width;
  logic [bb3_pkg::HeightW-1:0] cfg_height;
  int                          row_pos;
  int                          col_pos;
  int                          sum_two_back;
  int                          sum_one_back;

  blur_result_t blurred_pixels [$];
  int           mismatch_count = 0;
  int           burst_left     = 0;
  int           ready_left     = 0;
  ready_mode_e  ready_mode     = READY_ALWAYS;

  function automatic int eff_width();
    if (cfg_width < 2) return 2;
    if (cfg_width > bb3_pkg::MaxWidth) return bb3_pkg::MaxWidth;
    return cfg_width;
  endfunction

  function automatic int eff_height();
    return (cfg_height < 2) ? 2 : cfg_height;
  endfunction

  function automatic blur_result_t mean_of(int sum, int count);
    blur_result_t res;
    res.smoothed     = 8'(sum / count);
    res.last_of_run  = 1'b0;
    res.end_of_image = 1'b0;
    return res;
  endfunction

  // Works out every result one accepted pixel causes. With force_mean set the
  // smoothed value is the one typed into the stimulus table.
  task automatic predict_blur(input logic [7:0] pix, input bit force_mean,
                              input logic [7:0] mean);
    blur_result_t run [$];
    int w, h, r, c, top, mid, col_sum, rows, sum, cols, lo, hi, j, k;
    w = eff_width();
    h = eff_height();
    r = row_pos;
    c = col_pos;
    if (c >= w) c = w - 1;
    top     = line_older[c];
    mid     = line_newer[c];
    rows    = (r >= 2) ? 3 : 2;
    col_sum = mid + pix + ((r >= 2) ? top : 0);
    if (r >= 1) begin
      if (c >= 2) begin
        run.push_back(mean_of(sum_two_back + sum_one_back + col_sum, rows * 3));
      end else if (c == 1) begin
        run.push_back(mean_of(sum_one_back + col_sum, rows * 2));
      end
      if (c == w - 1) run.push_back(mean_of(sum_one_back + col_sum, rows * 2));
    end
    sum_two_back  = sum_one_back;
    sum_one_back  = col_sum;
    line_older[c] = 8'(mid);
    line_newer[c] = pix;
    if (c == w - 1) begin
      col_pos = 0;
      if (r >= h - 1) begin
        // The final row has no row below it: flush it from the line stores.
        for (j = 0; j < w; j++) begin
          sum  = 0;
          cols = 0;
          lo   = (j == 0) ? 0 : j - 1;
          hi   = (j + 1 < w) ? j + 1 : j;
          for (k = lo; k <= hi; k++) begin
            sum  += line_older[k] + line_newer[k];
            cols += 1;
          end
          run.push_back(mean_of(sum, cols * 2));
        end
        run[run.size() - 1].end_of_image = 1'b1;
        row_pos = 0;
      end else begin
        row_pos = (r + 1) & 12'hFFF;
      end
    end else begin
      col_pos = c + 1;
    end
    if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
    foreach (run[i]) begin
      if (force_mean) run[i].smoothed = mean;
      blurred_pixels.push_back(run[i]);
    end
  endtask

  // Lets the block drain completely, including any first-row pixels that are
  // still in flight without a result.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (blurred_pixels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [bb3_pkg::CfgIdxW-1:0] idx,
                           input logic [bb3_pkg::CfgDataW-1:0] data);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == bb3_pkg::CfgImageWidth) begin
      cfg_width = data[bb3_pkg::WidthW-1:0];
      row_pos   = 0;
      col_pos   = 0;
    end else if (idx == bb3_pkg::CfgImageHeight) begin
      cfg_height = data[bb3_pkg::HeightW-1:0];
      row_pos    = 0;
      col_pos    = 0;
    end
  endtask

  task automatic send_pixel(input logic [7:0] pix, input bit force_mean,
                            input logic [7:0] mean);
    int gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= pix;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_blur(pix, force_mean, mean);
    if ($urandom_range(0, 59) == 0) begin
      // Hold off until the output side has caught up completely.
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while (blurred_pixels.size() != 0);
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      gap        = $urandom_range(1, 6);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Output stall pattern: always ready, ready half the time, or sparsely ready.
  always @(posedge clk_i) begin
    if (ready_left == 0) begin
      ready_left = $urandom_range(16, 128);
      ready_mode = ready_mode_e'($urandom_range(0, 2));
    end else begin
      ready_left--;
    end
    case (ready_mode)
      READY_ALWAYS: m_axis_tready_i <= 1'b1;
      READY_HALF:   m_axis_tready_i <= 1'($urandom_range(0, 1));
      default:      m_axis_tready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    blur_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (blurred_pixels.size() == 0) begin
        $display("%0t: unexpected transfer, actual smoothed %0d last %b end %b",
                 $time, m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
        mismatch_count++;
      end else begin
        want = blurred_pixels.pop_front();
        if (m_axis_tdata_o !== want.smoothed) begin
          $display("%0t: smoothed expected %0d actual %0d",
                   $time, want.smoothed, m_axis_tdata_o);
          mismatch_count++;
        end
        if (m_axis_tlast_o !== want.last_of_run) begin
          $display("%0t: last_of_run expected %b actual %b",
                   $time, want.last_of_run, m_axis_tlast_o);
          mismatch_count++;
        end
        if (m_axis_tuser_o !== want.end_of_image) begin
          $display("%0t: end_of_image expected %b actual %b",
                   $time, want.end_of_image, m_axis_tuser_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int         i, pick, wval, hval, image, count, random_sent;
    logic [1:0] write_mask;
    logic [7:0] pix;
    foreach (line_older[n]) begin
      line_older[n] = '0;
      line_newer[n] = '0;
    end
    cfg_width    = bb3_pkg::WidthReset;
    cfg_height   = bb3_pkg::HeightReset;
    row_pos      = 0;
    col_pos      = 0;
    sum_two_back = 0;
    sum_one_back = 0;
    random_sent  = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < NumDirected; i++) begin
      case (DirectedRows[i].kind)
        ROW_CFG: cfg_write(DirectedRows[i].index, DirectedRows[i].value);
        ROW_PIX: send_pixel(DirectedRows[i].value[7:0], 1'b0, 8'd0);
        default: send_pixel(DirectedRows[i].value[7:0], 1'b1, DirectedRows[i].mean);
      endcase
    end

    // Random images. The first one is full width so that the end-of-image
    // flush produces the largest run of results.
    while (random_sent < RandomItems) begin
      if (random_sent == 0) begin
        wval       = bb3_pkg::MaxWidth;
        hval       = 2;
        write_mask = 2'b11;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 7)       wval = $urandom_range(2, 6);
        else if (pick == 7) wval = $urandom_range(0, 1);
        else if (pick == 8) wval = $urandom_range(32, 63);
        else                wval = $urandom_range(7, 31);
        pick = $urandom_range(0, 19);
        if (pick < 12)      hval = $urandom_range(2, 4);
        else if (pick < 15) hval = $urandom_range(0, 1);
        else if (pick < 17) hval = 4095;
        else                hval = $urandom_range(5, 8);
        pick       = $urandom_range(0, 19);
        write_mask = (pick < 14) ? 2'b11 : (pick < 17) ? 2'b01 : 2'b10;
      end
      if (write_mask[0]) begin
        cfg_write(bb3_pkg::CfgImageWidth, {6'($urandom_range(0, 63)), 6'(wval)});
      end
      if (write_mask[1]) cfg_write(bb3_pkg::CfgImageHeight, 12'(hval));
      if ($urandom_range(0, 4) == 0) begin
        cfg_write(($urandom_range(0, 1) != 0) ? CfgSpareA : CfgSpareB, 12'($urandom));
      end

      // Large images are cut short after a few rows by the next restart.
      image = eff_width() * eff_height();
      if (random_sent == 0) begin
        count = image;
      end else if (image > 80) begin
        count = eff_width() * $urandom_range(1, 3) + $urandom_range(0, eff_width() - 1);
      end else if ($urandom_range(0, 3) == 0) begin
        count = $urandom_range(1, image);
      end else begin
        count = image * $urandom_range(1, 2);
      end
      repeat (count) begin
        if (random_sent < RandomItems) begin
          if ($urandom_range(0, 7) == 0) pix = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
          else                           pix = 8'($urandom_range(0, 255));
          send_pixel(pix, 1'b0, 8'd0);
          random_sent++;
        end
      end
    end

    wait_drained();
    if (mismatch_count == 0) $display("== PASS ==");
    else                     $display("== FAIL ==");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
